/* rtl/core/sprite_animation_sequencer_defines.svh */
// Assertion macros for the sprite animation sequencer.
// Included by the top level; no other dependencies.
`ifndef SPRITE_ANIMATION_SEQUENCER_DEFINES_SVH
`define SPRITE_ANIMATION_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SAS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define SAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/sas_pkg.sv */
// Shared types and constants for the sprite animation sequencer.
// No dependencies; imported by every module of the block.
package sas_pkg;

   localparam int NUM_ANIMS   = 16;
   localparam int MAX_FRAMES  = 64;
   localparam int ANIM_W      = 4;
   localparam int FRAME_W     = 6;
   localparam int CNT_W       = 7;
   localparam int OP_W        = 3;
   localparam int CSR_W       = 8;
   localparam int CSR_IDX_W   = 2;

   // request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_TICK        = 3'd0,
      OP_SET_ANIM    = 3'd1,
      OP_QUEUE_AFTER = 3'd2,
      OP_CLEAR_QUEUE = 3'd3,
      OP_STOP_LOOP   = 3'd4,
      OP_STOP_AFTER  = 3'd5,
      OP_LOAD_COUNT  = 3'd6
   } op_type;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_PERIOD      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOPS_BEFORE_NEXT = 2'd1;

   typedef struct packed {
      logic [CSR_W-1:0] frame_period;
      logic [CSR_W-1:0] loops_before_next;
   } cfg_type;

   typedef struct packed {
      op_type            op;
      logic [ANIM_W-1:0] anim_idx;
      logic [CNT_W-1:0]  frame_count;
   } item_type;

   typedef struct packed {
      logic              en;
      logic [ANIM_W-1:0] addr;
   } tbl_rd_type;

   typedef struct packed {
      logic              en;
      logic [ANIM_W-1:0] addr;
      logic [CNT_W-1:0]  data;
   } tbl_wr_type;

   typedef struct packed {
      logic [ANIM_W-1:0]  shown_anim;
      logic [FRAME_W-1:0] shown_frame;
      logic               period_elapsed;
      logic               chained;
   } result_type;

endpackage

/* rtl/core/sprite_animation_sequencer.sv */
// Sprite animation sequencer top level: handshake, config registers, pipeline.
// Depends on sas_pkg, sas_frame_table, sas_seq_core and the defines header.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  operation, anim_index, frame_count
//   rsp_      out        rsp_valid/rsp_stall  shown_anim, shown_frame, period_elapsed, chained
//   csr_      in         csr_write_enable     csr_index, csr_write_data
//
// One request per cycle sustained while responses are not stalled. An accepted request
// reads the frame-count table and enters the execute register; the execute stage
// updates state and loads the response register. A table write in the update cycle is
// bypassed to a read in the same cycle. Reset is synchronous; no clearing pass is needed.
// A stalled response holds the update stage, which then stalls requests.
`include "sprite_animation_sequencer_defines.svh"

module sprite_animation_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sas_pkg::OP_W-1:0]          req_operation,
   input  logic [sas_pkg::ANIM_W-1:0]        req_anim_index,
   input  logic [sas_pkg::CNT_W-1:0]         req_frame_count,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sas_pkg::ANIM_W-1:0]        rsp_shown_anim,
   output logic [sas_pkg::FRAME_W-1:0]       rsp_shown_frame,
   output logic                              rsp_period_elapsed,
   output logic                              rsp_chained,
   input  logic                              csr_write_enable,
   input  logic [sas_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sas_pkg::CSR_W-1:0]         csr_write_data
);
   import sas_pkg::*;

   cfg_type    cfg_ff;
   logic       x_valid_ff, x_valid_in;
   item_type   x_item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type result;
   tbl_rd_type tbl_rd;
   tbl_wr_type tbl_wr;
   logic [CNT_W-1:0] tbl_rdata;
   logic       req_accept;
   logic       x_go;

   // pipeline control
   assign x_go       = x_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = x_valid_ff && !x_go;
   assign req_accept = req_valid && !req_stall;
   assign x_valid_in = req_accept || (x_valid_ff && !x_go);
   assign rsp_valid_in = x_go || (rsp_valid_ff && rsp_stall);

   assign tbl_rd.en   = req_accept;
   assign tbl_rd.addr = req_anim_index;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_period      <= CSR_W'(1);
         cfg_ff.loops_before_next <= CSR_W'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_PERIOD:      cfg_ff.frame_period      <= csr_write_data;
            CSR_LOOPS_BEFORE_NEXT: cfg_ff.loops_before_next <= csr_write_data;
            default: ;
         endcase
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         x_valid_ff   <= x_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         x_item_ff.op          <= op_type'(req_operation);
         x_item_ff.anim_idx    <= req_anim_index;
         x_item_ff.frame_count <= req_frame_count;
      end
      if (x_go) rsp_ff <= result;
   end

   sas_frame_table u_table (
      .clock   (clock),
      .reset   (reset),
      .rd      (tbl_rd),
      .wr      (tbl_wr),
      .rd_data (tbl_rdata)
   );

   sas_seq_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .exec_go   (x_go),
      .item      (x_item_ff),
      .tbl_rdata (tbl_rdata),
      .tbl_wr    (tbl_wr),
      .result    (result)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_shown_anim     = rsp_ff.shown_anim;
   assign rsp_shown_frame    = rsp_ff.shown_frame;
   assign rsp_period_elapsed = rsp_ff.period_elapsed;
   assign rsp_chained        = rsp_ff.chained;

   // checks
   `SAS_ASSERT_NOW(a_chain_elapsed, clock, reset, rsp_valid_ff && rsp_ff.chained,
      rsp_ff.period_elapsed, "chained response without elapsed period")
   `SAS_ASSERT_NOW(a_chain_frame0, clock, reset, rsp_valid_ff && rsp_ff.chained,
      rsp_ff.shown_frame == '0, "chained response not at frame 0")
   `SAS_ASSERT_NOW(a_stall_busy, clock, reset, req_stall,
      x_valid_ff && rsp_valid_ff, "request stalled with free pipeline")
   `SAS_ASSERT_NEXT(a_go_rsp, clock, reset, x_go,
      rsp_valid_ff, "executed request produced no response")

endmodule

/* rtl/core/sas_frame_table.sv */
// Frame-count table: one entry per animation, synchronous read.
// Depends on sas_pkg. Entries never written read as one frame.
module sas_frame_table (
   input  logic                        clock,
   input  logic                        reset,
   input  sas_pkg::tbl_rd_type         rd,
   input  sas_pkg::tbl_wr_type         wr,
   output logic [sas_pkg::CNT_W-1:0]   rd_data
);
   import sas_pkg::*;

   logic [CNT_W-1:0] mem [NUM_ANIMS];
   logic             valid_ff [NUM_ANIMS];
   logic [CNT_W-1:0] rd_data_ff;
   logic             rd_valid_ff;

   // per-entry written flags, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ANIMS; i++) valid_ff[i] <= 1'b0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   // storage and registered read; a same-cycle write to the read entry is bypassed
   always_ff @(posedge clock) begin
      if (wr.en) mem[wr.addr] <= wr.data;
      if (rd.en) begin
         if (wr.en && (wr.addr == rd.addr)) begin
            rd_data_ff  <= wr.data;
            rd_valid_ff <= 1'b1;
         end else begin
            rd_data_ff  <= mem[rd.addr];
            rd_valid_ff <= valid_ff[rd.addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : CNT_W'(1);

endmodule

/* rtl/core/sas_seq_core.sv */
// Sequencer state and per-request update: frame stepping, looping, chaining.
// Depends on sas_pkg; takes the frame-table read data, drives the table write.
module sas_seq_core (
   input  logic                        clock,
   input  logic                        reset,
   input  sas_pkg::cfg_type            cfg,
   input  logic                        exec_go,
   input  sas_pkg::item_type           item,
   input  logic [sas_pkg::CNT_W-1:0]   tbl_rdata,
   output sas_pkg::tbl_wr_type         tbl_wr,
   output sas_pkg::result_type         result
);
   import sas_pkg::*;

   logic [ANIM_W-1:0]  current_anim_ff, current_anim_in;
   logic [FRAME_W-1:0] current_frame_ff, current_frame_in;
   logic [7:0]         hold_count_ff, hold_count_in;
   logic [7:0]         loop_count_ff, loop_count_in;
   logic [ANIM_W-1:0]  queued_anim_ff, queued_anim_in;
   logic               queued_valid_ff, queued_valid_in;
   logic               hold_last_ff, hold_last_in;
   logic               hold_last_after_ff, hold_last_after_in;
   // frame counts of the current and queued animations, kept beside the table
   logic [CNT_W-1:0]   cur_len_ff, cur_len_in;
   logic [CNT_W-1:0]   q_len_ff, q_len_in;

   logic               anim_ok;
   logic [CNT_W-1:0]   cnt_clamped;
   logic [7:0]         hold_next;
   logic [7:0]         target_m1;
   logic [CNT_W-1:0]   last_frame;
   logic               elapsed;
   logic               chain;

   assign anim_ok     = int'(item.anim_idx) < NUM_ANIMS;
   assign cnt_clamped = (item.frame_count == '0) ? CNT_W'(1) :
                        (int'(item.frame_count) > MAX_FRAMES) ? CNT_W'(MAX_FRAMES) :
                        item.frame_count;
   assign hold_next   = hold_count_ff + 8'd1;
   assign target_m1   = (cfg.loops_before_next == '0) ? 8'd0 :
                        cfg.loops_before_next - 8'd1;
   assign last_frame  = cur_len_ff - CNT_W'(1);

   // next state for the request in the execute stage
   always_comb begin
      current_anim_in    = current_anim_ff;
      current_frame_in   = current_frame_ff;
      hold_count_in      = hold_count_ff;
      loop_count_in      = loop_count_ff;
      queued_anim_in     = queued_anim_ff;
      queued_valid_in    = queued_valid_ff;
      hold_last_in       = hold_last_ff;
      hold_last_after_in = hold_last_after_ff;
      cur_len_in         = cur_len_ff;
      q_len_in           = q_len_ff;
      elapsed            = 1'b0;
      chain              = 1'b0;
      tbl_wr.en          = 1'b0;
      tbl_wr.addr        = item.anim_idx;
      tbl_wr.data        = cnt_clamped;
      case (item.op)
         OP_TICK: begin
            hold_count_in = hold_next;
            if (hold_next >= cfg.frame_period) begin
               elapsed       = 1'b1;
               hold_count_in = 8'd0;
               if ({1'b0, current_frame_ff} >= last_frame) begin
                  if (queued_valid_ff && (loop_count_ff >= target_m1)) begin
                     chain              = 1'b1;
                     current_anim_in    = queued_anim_ff;
                     current_frame_in   = '0;
                     loop_count_in      = 8'd0;
                     hold_last_in       = hold_last_after_ff;
                     hold_last_after_in = 1'b0;
                     queued_valid_in    = 1'b0;
                     cur_len_in         = q_len_ff;
                  end else if (!hold_last_ff) begin
                     current_frame_in = '0;
                     if (loop_count_ff != 8'hFF) loop_count_in = loop_count_ff + 8'd1;
                  end
               end else begin
                  current_frame_in = current_frame_ff + FRAME_W'(1);
               end
            end
         end
         OP_SET_ANIM: begin
            if (anim_ok) begin
               current_anim_in  = item.anim_idx;
               current_frame_in = '0;
               hold_last_in     = 1'b0;
               loop_count_in    = 8'd0;
               cur_len_in       = tbl_rdata;
            end
         end
         OP_QUEUE_AFTER: begin
            if (anim_ok) begin
               queued_anim_in     = item.anim_idx;
               queued_valid_in    = 1'b1;
               hold_last_after_in = 1'b0;
               q_len_in           = tbl_rdata;
            end
         end
         OP_CLEAR_QUEUE: queued_valid_in = 1'b0;
         OP_STOP_LOOP:   hold_last_in = 1'b1;
         OP_STOP_AFTER:  hold_last_after_in = 1'b1;
         OP_LOAD_COUNT: begin
            if (anim_ok) begin
               tbl_wr.en = exec_go;
               if (item.anim_idx == current_anim_ff) cur_len_in = cnt_clamped;
               if (item.anim_idx == queued_anim_ff)  q_len_in   = cnt_clamped;
            end
         end
         default: ;
      endcase
   end

   // a tick that does not chain shows the frame from before the advance
   assign result.shown_anim     = current_anim_in;
   assign result.shown_frame    = ((item.op == OP_TICK) && !chain) ? current_frame_ff :
                                  current_frame_in;
   assign result.period_elapsed = elapsed;
   assign result.chained        = chain;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         current_anim_ff    <= '0;
         current_frame_ff   <= '0;
         hold_count_ff      <= '0;
         loop_count_ff      <= '0;
         queued_anim_ff     <= '0;
         queued_valid_ff    <= 1'b0;
         hold_last_ff       <= 1'b0;
         hold_last_after_ff <= 1'b0;
         cur_len_ff         <= CNT_W'(1);
         q_len_ff           <= CNT_W'(1);
      end else if (exec_go) begin
         current_anim_ff    <= current_anim_in;
         current_frame_ff   <= current_frame_in;
         hold_count_ff      <= hold_count_in;
         loop_count_ff      <= loop_count_in;
         queued_anim_ff     <= queued_anim_in;
         queued_valid_ff    <= queued_valid_in;
         hold_last_ff       <= hold_last_in;
         hold_last_after_ff <= hold_last_after_in;
         cur_len_ff         <= cur_len_in;
         q_len_ff           <= q_len_in;
      end
   end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the sprite animation sequencer.
// Holds its own frame-sequencing predictor; depends on sas_pkg and the block's RTL.

module tb_top;
   import sas_pkg::*;

   // operation code 7 has no enum member; the block must treat it as a no-op
   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int DRAIN_CYCLES    = 4;
   localparam int MAX_REPORTS     = 50;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [OP_W-1:0]      req_operation = '0;
   logic [ANIM_W-1:0]    req_anim_index = '0;
   logic [CNT_W-1:0]     req_frame_count = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [ANIM_W-1:0]    rsp_shown_anim;
   logic [FRAME_W-1:0]   rsp_shown_frame;
   logic                 rsp_period_elapsed;
   logic                 rsp_chained;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_write_data = '0;

   sprite_animation_sequencer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_anim_index     (req_anim_index),
      .req_frame_count    (req_frame_count),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_shown_anim     (rsp_shown_anim),
      .rsp_shown_frame    (rsp_shown_frame),
      .rsp_period_elapsed (rsp_period_elapsed),
      .rsp_chained        (rsp_chained),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // sequencer shadow state
   logic [ANIM_W-1:0]  anim_now, next_anim;
   logic [FRAME_W-1:0] frame_now;
   logic [7:0]         tick_count, loops_done;
   logic               next_pending, freeze_last, freeze_after;
   logic [CNT_W-1:0]   frame_table [NUM_ANIMS];
   logic [CSR_W-1:0]   period_cfg, loop_target_cfg;

   result_type expected_frames [$];
   int fail_count  = 0;
   int idle_level  = 1;   // 0: no gaps or random stalls, 1: random gaps and stalls
   bit hold_req    = 1'b0;
   int hold_left   = 0;
   int seg_left    = 0;
   int idle_cycles = 0;

   function automatic void clear_sequencer_model();
      anim_now        = '0;
      frame_now       = '0;
      tick_count      = '0;
      loops_done      = '0;
      next_anim       = '0;
      next_pending    = 1'b0;
      freeze_last     = 1'b0;
      freeze_after    = 1'b0;
      period_cfg      = 8'd1;
      loop_target_cfg = 8'd1;
      for (int i = 0; i < NUM_ANIMS; i++) frame_table[i] = 7'd1;
   endfunction

   // Advance the shadow sequencer by one request; returns the frame it shows
   function automatic result_type predict_frame(logic [OP_W-1:0] op, logic [ANIM_W-1:0] idx,
                                                logic [CNT_W-1:0] cnt);
      result_type r;
      logic [CNT_W-1:0] last;
      int target;
      r = '0;
      r.shown_anim  = anim_now;
      r.shown_frame = frame_now;
      case (op)
         OP_TICK: begin
            tick_count = tick_count + 8'd1;
            if (tick_count >= period_cfg) begin
               last   = frame_table[anim_now] - 7'd1;
               target = (loop_target_cfg == 8'd0) ? 1 : int'(loop_target_cfg);
               r.period_elapsed = 1'b1;
               // a frame past the end counts as the last frame
               if ({1'b0, frame_now} >= last) begin
                  if (next_pending && int'(loops_done) >= target - 1) begin
                     anim_now      = next_anim;
                     frame_now     = '0;
                     loops_done    = '0;
                     freeze_last   = freeze_after;
                     freeze_after  = 1'b0;
                     next_pending  = 1'b0;
                     r.chained     = 1'b1;
                     r.shown_anim  = anim_now;
                     r.shown_frame = frame_now;
                  end else if (!freeze_last) begin
                     frame_now = '0;
                     if (loops_done != 8'd255) loops_done = loops_done + 8'd1;
                  end
               end else begin
                  frame_now = frame_now + 6'd1;
               end
               tick_count = '0;
            end
         end
         OP_SET_ANIM: begin
            anim_now    = idx;
            frame_now   = '0;
            freeze_last = 1'b0;
            loops_done  = '0;
         end
         OP_QUEUE_AFTER: begin
            next_anim    = idx;
            next_pending = 1'b1;
            freeze_after = 1'b0;
         end
         OP_CLEAR_QUEUE: next_pending = 1'b0;
         OP_STOP_LOOP:   freeze_last  = 1'b1;
         OP_STOP_AFTER:  freeze_after = 1'b1;
         OP_LOAD_COUNT: begin
            if (cnt == '0) frame_table[idx] = 7'd1;
            else if (cnt > MAX_FRAMES) frame_table[idx] = CNT_W'(MAX_FRAMES);
            else frame_table[idx] = cnt;
         end
         default: ;
      endcase
      if (op != OP_TICK) begin
         r.shown_anim  = anim_now;
         r.shown_frame = frame_now;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   // predict every accepted request
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         expected_frames.push_back(predict_frame(req_operation, req_anim_index, req_frame_count));
   end

   // compare every accepted response with the oldest prediction
   always @(posedge clock) begin : check_responses
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_frames.size() == 0) begin
            report_mismatch("response with nothing outstanding", 0, 0);
         end else begin
            want = expected_frames.pop_front();
            if (rsp_shown_anim != want.shown_anim)
               report_mismatch("shown_anim", rsp_shown_anim, want.shown_anim);
            if (rsp_shown_frame != want.shown_frame)
               report_mismatch("shown_frame", rsp_shown_frame, want.shown_frame);
            if (rsp_period_elapsed != want.period_elapsed)
               report_mismatch("period_elapsed", rsp_period_elapsed, want.period_elapsed);
            if (rsp_chained != want.chained)
               report_mismatch("chained", rsp_chained, want.chained);
         end
      end
   end

   // idle lengths: mostly short, a few long
   function automatic int pick_idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_gap();
      if (idle_level == 0) return 0;
      if ($urandom_range(0, 99) < 55) return 0;
      return pick_idle_len();
   endfunction

   // response stall: long hold-off on demand, otherwise random segments
   always @(posedge clock) begin : drive_rsp_stall
      bit stall_now;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_req) begin
         hold_req  = 1'b0;
         hold_left = HOLD_OFF_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (seg_left > 0) begin
         seg_left--;
      end else if (idle_level == 0) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_now = ($urandom_range(0, 99) < 30);
         seg_left  = stall_now ? pick_idle_len() : $urandom_range(0, 8);
         rsp_stall <= stall_now;
      end
   end

   // watchdog on cycles with no request or response accepted
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
         $display("** sprite_animation_sequencer: FAILED **");
         $finish;
      end
   end

   // send one request; returns at the edge where it is accepted
   task automatic send_request(logic [OP_W-1:0] op, logic [ANIM_W-1:0] idx,
                               logic [CNT_W-1:0] cnt);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_anim_index  <= idx;
      req_frame_count <= cnt;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_ticks(int n);
      repeat (n) send_request(OP_TICK, ANIM_W'($urandom), CNT_W'($urandom));
   endtask

   // stop sending and wait for every outstanding response
   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      if (idx == CSR_FRAME_PERIOD) period_cfg = data;
      else if (idx == CSR_LOOPS_BEFORE_NEXT) loop_target_cfg = data;
   endtask

   task automatic configure(logic [CSR_W-1:0] period, logic [CSR_W-1:0] loops);
      wait_drain();
      write_csr(CSR_FRAME_PERIOD, period);
      write_csr(CSR_LOOPS_BEFORE_NEXT, loops);
   endtask

   // one random request, biased toward a few animations so loaded counts matter
   task automatic send_random_request();
      logic [OP_W-1:0]   op;
      logic [ANIM_W-1:0] idx;
      logic [CNT_W-1:0]  cnt;
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) op = OP_TICK;
      else if (r < 58) op = OP_SET_ANIM;
      else if (r < 68) op = OP_QUEUE_AFTER;
      else if (r < 72) op = OP_CLEAR_QUEUE;
      else if (r < 77) op = OP_STOP_LOOP;
      else if (r < 82) op = OP_STOP_AFTER;
      else if (r < 96) op = OP_LOAD_COUNT;
      else op = OP_UNUSED;
      idx = ($urandom_range(0, 99) < 70) ? ANIM_W'($urandom_range(0, 3)) : ANIM_W'($urandom);
      cnt = ($urandom_range(0, 99) < 80) ? CNT_W'($urandom_range(0, 6)) : CNT_W'($urandom);
      send_request(op, idx, cnt);
   endtask

   // reset state, op 7, count clamping, frame past end, stop-after chaining, hold
   task automatic test_directed();
      idle_level = 1;
      send_request(OP_TICK, 4'd0, 7'd0);
      send_request(OP_UNUSED, 4'd9, 7'd5);
      send_request(OP_LOAD_COUNT, 4'd3, 7'd0);
      send_request(OP_LOAD_COUNT, 4'd5, 7'd127);
      send_request(OP_LOAD_COUNT, 4'd2, 7'd4);
      send_request(OP_SET_ANIM, 4'd2, 7'd0);
      send_ticks(3);
      // shrink the table under the current frame
      send_request(OP_LOAD_COUNT, 4'd2, 7'd2);
      send_ticks(1);
      send_request(OP_QUEUE_AFTER, 4'd5, 7'd0);
      send_request(OP_STOP_AFTER, 4'd0, 7'd0);
      send_ticks(3);
      send_request(OP_LOAD_COUNT, 4'd15, 7'd64);
      send_request(OP_LOAD_COUNT, 4'd15, 7'd1);
      send_request(OP_SET_ANIM, 4'd15, 7'd0);
      send_request(OP_STOP_LOOP, 4'd0, 7'd0);
      send_ticks(2);
      send_request(OP_QUEUE_AFTER, 4'd3, 7'd0);
      send_request(OP_CLEAR_QUEUE, 4'd0, 7'd0);
      send_ticks(1);
   endtask

   // a zero loop target chains at the first last frame
   task automatic test_zero_loop_target();
      configure(8'd1, 8'd0);
      send_request(OP_SET_ANIM, 4'd2, 7'd0);
      send_request(OP_QUEUE_AFTER, 4'd3, 7'd0);
      send_ticks(4);
      send_request(OP_SET_ANIM, 4'd5, 7'd0);
      send_request(OP_QUEUE_AFTER, 4'd2, 7'd0);
      send_ticks(70);
   endtask

   // period 0 advances every tick; period 255 holds a frame for 255 ticks
   task automatic test_period_extremes();
      configure(8'd0, 8'd2);
      send_request(OP_LOAD_COUNT, 4'd6, 7'd3);
      send_request(OP_SET_ANIM, 4'd6, 7'd0);
      send_ticks(8);
      configure(8'd255, 8'd2);
      send_request(OP_SET_ANIM, 4'd6, 7'd0);
      send_ticks(260);
   endtask

   // loop count saturates at 255 and still chains at the top target
   task automatic test_loop_saturation();
      configure(8'd1, 8'd255);
      send_request(OP_LOAD_COUNT, 4'd7, 7'd1);
      send_request(OP_SET_ANIM, 4'd7, 7'd0);
      send_ticks(262);
      send_request(OP_QUEUE_AFTER, 4'd8, 7'd0);
      send_ticks(3);
   endtask

   // long response hold-off with requests streaming, then a full pause
   task automatic test_backpressure();
      configure(8'd1, 8'd2);
      idle_level = 0;
      hold_req   = 1'b1;
      repeat (60) send_random_request();
      wait_drain();
      idle_level = 1;
      repeat (20) send_random_request();
   endtask

   // random phases over several register settings, some without any idling
   task automatic test_random();
      logic [CSR_W-1:0] period, loops;
      for (int phase = 0; phase < 10; phase++) begin
         period = CSR_W'($urandom_range(0, 3));
         loops  = ($urandom_range(0, 99) < 20) ? 8'd0 : CSR_W'($urandom_range(1, 3));
         if (phase == 9) loops = 8'd255;
         configure(period, loops);
         idle_level = (phase % 3 == 0) ? 0 : 1;
         for (int n = 0; n < 60; n++) begin
            // a well-formed play-then-chain sequence now and then
            if ($urandom_range(0, 99) < 8) begin
               send_request(OP_SET_ANIM, ANIM_W'($urandom_range(0, 3)), 7'd0);
               send_request(OP_QUEUE_AFTER, ANIM_W'($urandom_range(0, 3)), 7'd0);
               send_ticks($urandom_range(2, 12));
            end else begin
               send_random_request();
            end
         end
      end
      idle_level = 1;
   endtask

   initial begin
      clear_sequencer_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_zero_loop_target();
      test_period_extremes();
      test_loop_saturation();
      test_backpressure();
      test_random();
      wait_drain();
      if (fail_count == 0) begin
         $display("** sprite_animation_sequencer: PASSED **");
      end else begin
         $display("** sprite_animation_sequencer: FAILED **");
      end
      $finish;
   end

endmodule
